[design/ptt_pkg.sv]
// Package for the pan/tilt tracking controller: image geometry, fixed-point
// constants, divide-by-half reciprocals, register indexes and pipeline control type.
// No dependencies.
package ptt_pkg;

  // Downsampled image geometry (legal range 16..512 each)
  localparam int IMG_WIDTH  = 160;
  localparam int IMG_HEIGHT = 120;
  localparam int HALF_W     = IMG_WIDTH / 2;
  localparam int HALF_H     = IMG_HEIGHT / 2;

  // Field widths
  localparam int COORD_W = 9;
  localparam int DZ_W    = 7;
  localparam int GAIN_W  = 16;
  localparam int DEG_W   = 8;
  localparam int ANGLE_W = 16;   // Q8.8
  localparam int CNT_W   = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Datapath widths: error magnitude never exceeds 512 pixels
  localparam int ERR_W   = 11;
  localparam int MAG_W   = 10;
  localparam int PROD_W  = GAIN_W + MAG_W;
  localparam int QUO_W   = 24;
  localparam int DELTA_W = QUO_W + 1;
  localparam int SUM_W   = DELTA_W;

  // Exact floor division by the half size: q = (n * ceil(2^S / d)) >> S,
  // exact while n * d < 2^S.
  localparam int RECIP_SHIFT = 34;
  localparam int RECIP_W     = 32;
  localparam int FULL_W      = PROD_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_X = RECIP_W'(
      ((64'd1 << RECIP_SHIFT) + 64'(HALF_W) - 64'd1) / 64'(HALF_W));
  localparam logic [RECIP_W-1:0] RECIP_Y = RECIP_W'(
      ((64'd1 << RECIP_SHIFT) + 64'(HALF_H) - 64'd1) / 64'(HALF_H));

  // Error offsets: err_x = (W-1-W/2) - cx, err_y = cy - H/2
  localparam logic signed [ERR_W-1:0] ERR_X_BIAS = ERR_W'(IMG_WIDTH - 1 - HALF_W);
  localparam logic signed [ERR_W-1:0] ERR_Y_BIAS = ERR_W'(HALF_H);

  // Angle constants, Q8.8
  localparam logic [ANGLE_W-1:0] CENTRE_Q     = ANGLE_W'(90 * 256);
  localparam logic [ANGLE_W-1:0] ONE_Q        = ANGLE_W'(256);
  localparam logic [ANGLE_W-1:0] UPPER_SNAP_Q = ANGLE_W'(91 * 256);
  localparam logic [ANGLE_W-1:0] LOWER_SNAP_Q = ANGLE_W'(89 * 256);
  localparam logic [CNT_W-1:0]   CNT_MAX      = '1;

  // Register reset values
  localparam logic [DZ_W-1:0]   DEADBAND_RST       = DZ_W'(10);
  localparam logic [GAIN_W-1:0] LOOP_GAIN_RST      = GAIN_W'(512);
  localparam logic [DEG_W-1:0]  ANGLE_FLOOR_RST    = DEG_W'(10);
  localparam logic [DEG_W-1:0]  ANGLE_CEILING_RST  = DEG_W'(170);
  localparam logic [CNT_W-1:0]  LOST_THRESHOLD_RST = CNT_W'(30);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEADBAND       = 3'd0,
    CFG_LOOP_GAIN      = 3'd1,
    CFG_ANGLE_FLOOR    = 3'd2,
    CFG_ANGLE_CEILING  = 3'd3,
    CFG_LOST_THRESHOLD = 3'd4
  } ptt_cfg_idx_t;

  // Stage load enables handed to the axis pipelines
  typedef struct packed {
    logic load_b;
    logic load_c;
  } ptt_pipe_ctl_t;

endpackage

[design/pan_tilt_tracking_control_core.sv]
// Top level of the pan/tilt face-tracking controller.
// Depends on ptt_pkg and ptt_axis_pipe.
//
// One request per video frame: face_found plus a face box. The block returns one
// result per request: the integer pan and tilt angles after the frame, whether
// the servos are driven, and whether the lost-face recentering is active.
// Each request passes a four-stage pipeline (input register, gain multiply,
// reciprocal divide, angle update into the result register), and a new request
// is taken every cycle while no stalled result backs the pipeline up.
// The angle state is only read and written in the last stage, which keeps
// frame-to-frame updates in order. A result waiting on out_stall does not
// block the earlier stages from filling. Configuration writes are always
// ready and should be issued only while no request is in flight.
module pan_tilt_tracking_control_core
  import ptt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // request channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  face_found,
  input  logic [COORD_W-1:0]    box_left,
  input  logic [COORD_W-1:0]    box_top,
  input  logic [COORD_W-1:0]    box_right,
  input  logic [COORD_W-1:0]    box_bottom,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DEG_W-1:0]      pan_degrees,
  output logic [DEG_W-1:0]      tilt_degrees,
  output logic                  drive_servos,
  output logic                  recentering,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // config registers
  logic [DZ_W-1:0]   deadband;
  logic [GAIN_W-1:0] loop_gain;
  logic [DEG_W-1:0]  angle_floor;
  logic [DEG_W-1:0]  angle_ceiling;
  logic [CNT_W-1:0]  lost_threshold;

  // tracking state
  logic [ANGLE_W-1:0] pan_angle;
  logic [ANGLE_W-1:0] tilt_angle;
  logic [CNT_W-1:0]   missed_frames;
  logic [ANGLE_W-1:0] pan_angle_next;
  logic [ANGLE_W-1:0] tilt_angle_next;
  logic [CNT_W-1:0]   missed_frames_next;
  logic               drive_next;
  logic               recenter_next;

  // pipeline
  logic valid_a, valid_b, valid_c;
  logic ready_a, ready_b, ready_c, ready_d;
  logic load_d;
  ptt_pipe_ctl_t ctl;

  logic               found_a, found_b, found_c;
  logic [COORD_W-1:0] left_a, top_a, right_a, bottom_a;
  logic [COORD_W:0]   sum_x, sum_y;
  logic signed [ERR_W-1:0]   err_x, err_y;
  logic signed [DELTA_W-1:0] delta_x, delta_y;

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      deadband       <= DEADBAND_RST;
      loop_gain      <= LOOP_GAIN_RST;
      angle_floor    <= ANGLE_FLOOR_RST;
      angle_ceiling  <= ANGLE_CEILING_RST;
      lost_threshold <= LOST_THRESHOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DEADBAND:       deadband       <= cfg_data[DZ_W-1:0];
        CFG_LOOP_GAIN:      loop_gain      <= cfg_data[GAIN_W-1:0];
        CFG_ANGLE_FLOOR:    angle_floor    <= cfg_data[DEG_W-1:0];
        CFG_ANGLE_CEILING:  angle_ceiling  <= cfg_data[DEG_W-1:0];
        CFG_LOST_THRESHOLD: lost_threshold <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- flow control
  // Each stage moves when the one after it is empty or moving.
  always_comb begin
    ready_d    = !out_valid || !out_stall;
    ready_c    = !valid_c || ready_d;
    ready_b    = !valid_b || ready_c;
    ready_a    = !valid_a || ready_b;
    ctl.load_b = valid_a && ready_b;
    ctl.load_c = valid_b && ready_c;
    load_d     = valid_c && ready_d;
  end

  assign in_stall = !ready_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a   <= 1'b0;
      valid_b   <= 1'b0;
      valid_c   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ready_a) valid_a   <= in_valid;
      if (ready_b) valid_b   <= valid_a;
      if (ready_c) valid_c   <= valid_b;
      if (ready_d) out_valid <= valid_c;
    end
  end

  // ---------------------------------------------------------------- stage A
  always_ff @(posedge clk) begin
    if (in_valid && ready_a) begin
      found_a  <= face_found;
      left_a   <= box_left;
      top_a    <= box_top;
      right_a  <= box_right;
      bottom_a <= box_bottom;
    end
  end

  // Box centre (floored), x mirrored, errors against the image centre
  always_comb begin
    sum_x = {1'b0, left_a} + {1'b0, right_a};
    sum_y = {1'b0, top_a} + {1'b0, bottom_a};
    err_x = ERR_X_BIAS - $signed(ERR_W'(sum_x[COORD_W:1]));
    err_y = $signed(ERR_W'(sum_y[COORD_W:1])) - ERR_Y_BIAS;
  end

  // ---------------------------------------------------------------- stages B, C
  ptt_axis_pipe u_pan_pipe (
    .clk       (clk),
    .ctl       (ctl),
    .axis_tilt (1'b0),
    .err       (err_x),
    .deadband  (deadband),
    .loop_gain (loop_gain),
    .delta     (delta_x)
  );

  ptt_axis_pipe u_tilt_pipe (
    .clk       (clk),
    .ctl       (ctl),
    .axis_tilt (1'b1),
    .err       (err_y),
    .deadband  (deadband),
    .loop_gain (loop_gain),
    .delta     (delta_y)
  );

  always_ff @(posedge clk) begin
    if (ctl.load_b) found_b <= found_a;
    if (ctl.load_c) found_c <= found_b;
  end

  // ---------------------------------------------------------------- stage D
  // Floor test first, ceiling second: a floor above the ceiling ends at the ceiling.
  function automatic logic [ANGLE_W-1:0] clamp_angle(
    input logic signed [SUM_W-1:0] a,
    input logic [DEG_W-1:0]        lo_deg,
    input logic [DEG_W-1:0]        hi_deg
  );
    logic signed [SUM_W-1:0] lo;
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] r;
    lo = $signed(SUM_W'({lo_deg, 8'h00}));
    hi = $signed(SUM_W'({hi_deg, 8'h00}));
    r  = a;
    if (r < lo) r = lo;
    if (r > hi) r = hi;
    return r[ANGLE_W-1:0];
  endfunction

  // One degree toward centre; snap to exactly 90 inside 89..91
  function automatic logic [ANGLE_W:0] recentre_axis(input logic [ANGLE_W-1:0] a);
    logic [ANGLE_W:0] r;   // {moved, angle}
    if (a > UPPER_SNAP_Q) begin
      r = {1'b1, a - ONE_Q};
    end else if (a < LOWER_SNAP_Q) begin
      r = {1'b1, a + ONE_Q};
    end else begin
      r = {1'b0, CENTRE_Q};
    end
    return r;
  endfunction

  logic [ANGLE_W:0] pan_rc, tilt_rc;
  logic signed [SUM_W-1:0] pan_sum, tilt_sum;

  always_comb begin
    pan_sum  = $signed(SUM_W'(pan_angle)) + delta_x;
    tilt_sum = $signed(SUM_W'(tilt_angle)) - delta_y;
    pan_rc   = recentre_axis(pan_angle);
    tilt_rc  = recentre_axis(tilt_angle);

    pan_angle_next  = pan_angle;
    tilt_angle_next = tilt_angle;
    drive_next      = 1'b0;
    recenter_next   = 1'b0;

    if (found_c) begin
      missed_frames_next = '0;
      pan_angle_next     = clamp_angle(pan_sum, angle_floor, angle_ceiling);
      tilt_angle_next    = clamp_angle(tilt_sum, angle_floor, angle_ceiling);
      drive_next         = 1'b1;
    end else begin
      missed_frames_next = (missed_frames == CNT_MAX) ? CNT_MAX : missed_frames + 1'b1;
      if (missed_frames_next > lost_threshold) begin
        pan_angle_next  = pan_rc[ANGLE_W-1:0];
        tilt_angle_next = tilt_rc[ANGLE_W-1:0];
        recenter_next   = 1'b1;
        drive_next      = pan_rc[ANGLE_W] || tilt_rc[ANGLE_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pan_angle     <= CENTRE_Q;
      tilt_angle    <= CENTRE_Q;
      missed_frames <= '0;
    end else if (load_d) begin
      pan_angle     <= pan_angle_next;
      tilt_angle    <= tilt_angle_next;
      missed_frames <= missed_frames_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_d) begin
      drive_servos <= drive_next;
      recentering  <= recenter_next;
    end
  end

  // State only changes on a result load, so it doubles as the result payload.
  assign pan_degrees  = pan_angle[ANGLE_W-1:8];
  assign tilt_degrees = tilt_angle[ANGLE_W-1:8];

endmodule

[design/ptt_axis_pipe.sv]
// One axis of the step datapath: dead-zone test and gain multiply (stage B),
// then exact divide by the half size through a reciprocal multiply (stage C).
// Depends on ptt_pkg.
module ptt_axis_pipe
  import ptt_pkg::*;
(
  input  logic                      clk,
  input  ptt_pipe_ctl_t             ctl,
  input  logic                      axis_tilt,
  input  logic signed [ERR_W-1:0]   err,
  input  logic [DZ_W-1:0]           deadband,
  input  logic [GAIN_W-1:0]         loop_gain,
  output logic signed [DELTA_W-1:0] delta
);

  logic [MAG_W-1:0]   mag;
  logic               neg;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  prod_b;
  logic               neg_b;
  logic               hold_b;
  logic [RECIP_W-1:0] recip;
  logic [FULL_W-1:0]  full;
  logic [QUO_W-1:0]   quo;

  always_comb begin
    neg  = err[ERR_W-1];
    mag  = neg ? MAG_W'(-err) : MAG_W'(err);
    prod = PROD_W'(loop_gain) * PROD_W'(mag);
  end

  always_ff @(posedge clk) begin
    if (ctl.load_b) begin
      prod_b <= prod;
      neg_b  <= neg;
      hold_b <= (mag <= MAG_W'(deadband));
    end
  end

  // Truncation toward zero: divide the magnitude, then restore the sign
  always_comb begin
    recip = axis_tilt ? RECIP_Y : RECIP_X;
    full  = FULL_W'(prod_b) * FULL_W'(recip);
    quo   = full[RECIP_SHIFT +: QUO_W];
  end

  always_ff @(posedge clk) begin
    if (ctl.load_c) begin
      if (hold_b) begin
        delta <= '0;
      end else if (neg_b) begin
        delta <= -$signed({1'b0, quo});
      end else begin
        delta <= $signed({1'b0, quo});
      end
    end
  end

endmodule

[design/ptt_checker.sv]
// Port-level checker for the pan/tilt tracking controller, bound to the top level.
// Depends on ptt_pkg and pan_tilt_tracking_control_core.
module ptt_checker
  import ptt_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [DEG_W-1:0] pan_degrees,
  input logic [DEG_W-1:0] tilt_degrees
);

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");

  // Pipeline only backs up behind a stalled result.
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a stalled result");

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_angle_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(pan_degrees) && $stable(tilt_degrees))
    else $error("angles changed while result stalled");

endmodule

bind pan_tilt_tracking_control_core ptt_checker u_ptt_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .pan_degrees  (pan_degrees),
  .tilt_degrees (tilt_degrees)
);

[dv/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for pan_tilt_tracking_control_core: directed and random detection
// requests against an in-bench tracking predictor, results checked in order. Needs ptt_pkg.
module tb_top;
  import ptt_pkg::*;

  localparam int CYCLE_LIMIT = 200000;  // watchdog limit on the whole run
  localparam int DRAIN_LIMIT = 2000;
  localparam int PIPE_DEPTH  = 4;       // acceptance to result handshake

  // One detection request, field order matches the port list
  typedef struct packed {
    logic               found;
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] right;
    logic [COORD_W-1:0] bottom;
  } detect_req_t;

  // One servo command result
  typedef struct packed {
    logic [DEG_W-1:0] pan;
    logic [DEG_W-1:0] tilt;
    logic             drive;
    logic             recenter;
  } servo_cmd_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic                  face_found;
  logic [COORD_W-1:0]    box_left;
  logic [COORD_W-1:0]    box_top;
  logic [COORD_W-1:0]    box_right;
  logic [COORD_W-1:0]    box_bottom;
  logic                  out_valid;
  logic                  out_stall;
  logic [DEG_W-1:0]      pan_degrees;
  logic [DEG_W-1:0]      tilt_degrees;
  logic                  drive_servos;
  logic                  recentering;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Predictor copy of the registers and the tracking state
  logic [DZ_W-1:0]    deadband_q;
  logic [GAIN_W-1:0]  loop_gain_q;
  logic [DEG_W-1:0]   floor_deg_q;
  logic [DEG_W-1:0]   ceil_deg_q;
  logic [CNT_W-1:0]   lost_limit_q;
  logic [ANGLE_W-1:0] pan_q;
  logic [ANGLE_W-1:0] tilt_q;
  logic [CNT_W-1:0]   missed_q;

  servo_cmd_t expected_cmds[$];   // commands owed by the block, oldest first
  int bad_results = 0;
  int cycle_count = 0;
  int in_gap_pct;                 // sender idle chance per cycle, percent
  int out_stall_pct;              // receiver stall chance per cycle, percent

  pan_tilt_tracking_control_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .face_found   (face_found),
    .box_left     (box_left),
    .box_top      (box_top),
    .box_right    (box_right),
    .box_bottom   (box_bottom),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pan_degrees  (pan_degrees),
    .tilt_degrees (tilt_degrees),
    .drive_servos (drive_servos),
    .recentering  (recentering),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  //--------------------------------------------------------------------------
  // Predictor
  //--------------------------------------------------------------------------

  // Proportional move for one axis; inside the dead zone the axis holds.
  // SV signed int division truncates toward zero, which is what we want.
  function automatic int axis_step(int err, int half);
    int mag;
    mag = (err < 0) ? -err : err;
    if (mag <= int'(deadband_q)) return 0;
    return int'(loop_gain_q) * err / half;
  endfunction

  // Floor is applied first, so a floor above the ceiling ends at the ceiling
  function automatic logic [ANGLE_W-1:0] clamp_angle(int a);
    int lo;
    int hi;
    lo = int'(floor_deg_q) * int'(ONE_Q);
    hi = int'(ceil_deg_q) * int'(ONE_Q);
    if (a < lo) a = lo;
    if (a > hi) a = hi;
    return ANGLE_W'(a);
  endfunction

  // One degree toward center, or snap to center inside the 89..91 window
  function automatic logic [ANGLE_W-1:0] drift_home(logic [ANGLE_W-1:0] a);
    if (a > UPPER_SNAP_Q) return a - ONE_Q;
    if (a < LOWER_SNAP_Q) return a + ONE_Q;
    return CENTRE_Q;
  endfunction

  function automatic servo_cmd_t track_frame(detect_req_t req);
    servo_cmd_t cmd;
    int err_x;
    int err_y;
    cmd = '0;
    if (req.found) begin
      // x is mirrored: err_x = (W-1 - cx) - W/2
      err_x = (IMG_WIDTH - 1 - (int'(req.left) + int'(req.right)) / 2) - HALF_W;
      err_y = (int'(req.top) + int'(req.bottom)) / 2 - HALF_H;
      pan_q    = clamp_angle(int'(pan_q) + axis_step(err_x, HALF_W));
      tilt_q   = clamp_angle(int'(tilt_q) - axis_step(err_y, HALF_H));
      missed_q = '0;
      cmd.drive = 1'b1;
    end else begin
      if (missed_q != CNT_MAX) missed_q = missed_q + 1'b1;
      if (missed_q > lost_limit_q) begin
        pan_q  = drift_home(pan_q);
        tilt_q = drift_home(tilt_q);
        // an axis that stepped lands off center; a snapped one lands exactly on it
        cmd.drive    = (pan_q != CENTRE_Q) || (tilt_q != CENTRE_Q);
        cmd.recenter = 1'b1;
      end
    end
    cmd.pan  = pan_q[ANGLE_W-1:ANGLE_W-DEG_W];
    cmd.tilt = tilt_q[ANGLE_W-1:ANGLE_W-DEG_W];
    return cmd;
  endfunction

  function automatic void log_mismatch(string what, servo_cmd_t want, servo_cmd_t got);
    bad_results++;
    if (bad_results <= 10)
      $display({"%0t %s: exp pan %0d tilt %0d drive %0b recenter %0b",
                " | got pan %0d tilt %0d drive %0b recenter %0b"},
               $time, what, want.pan, want.tilt, want.drive, want.recenter,
               got.pan, got.tilt, got.drive, got.recenter);
  endfunction

  //--------------------------------------------------------------------------
  // Monitor: everything sampled at the rising edge, before the block updates.
  // Results are checked before the request of the same edge is predicted;
  // with each request registered through every pipeline stage before out_valid, they never belong to each other.
  //--------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    servo_cmd_t want;
    servo_cmd_t got;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got = {pan_degrees, tilt_degrees, drive_servos, recentering};
        if (expected_cmds.size() == 0) begin
          log_mismatch("result with no request pending", '0, got);
        end else begin
          want = expected_cmds.pop_front();
          if (got.pan !== want.pan || got.tilt !== want.tilt ||
              got.drive !== want.drive || got.recenter !== want.recenter)
            log_mismatch("result mismatch", want, got);
        end
      end
      if (in_valid && !in_stall)
        expected_cmds.push_back(track_frame({face_found, box_left, box_top,
                                             box_right, box_bottom}));
      if (cfg_valid && cfg_ready) begin
        case (ptt_cfg_idx_t'(cfg_index))
          CFG_DEADBAND:       deadband_q   = cfg_data[DZ_W-1:0];
          CFG_LOOP_GAIN:      loop_gain_q  = cfg_data[GAIN_W-1:0];
          CFG_ANGLE_FLOOR:    floor_deg_q  = cfg_data[DEG_W-1:0];
          CFG_ANGLE_CEILING:  ceil_deg_q   = cfg_data[DEG_W-1:0];
          CFG_LOST_THRESHOLD: lost_limit_q = cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Receiver back-pressure, redrawn every cycle
  always @(negedge clk)
    out_stall <= ($urandom_range(99) < out_stall_pct);

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  //--------------------------------------------------------------------------
  // Drivers. Every task is entered and left at a falling edge.
  //--------------------------------------------------------------------------

  // Send one request; in_valid stays high on return so that back-to-back
  // requests do not drop valid for a cycle. Callers lower it when done.
  task automatic send_frame(input detect_req_t req);
    while ($urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    face_found <= req.found;
    box_left   <= req.left;
    box_top    <= req.top;
    box_right  <= req.right;
    box_bottom <= req.bottom;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Stop sending and let every owed result come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_cmds.size() != 0) @(negedge clk);
  endtask

  // Leaves cfg_valid high; program_regs lowers it after the last write
  task automatic write_reg(input ptt_cfg_idx_t idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic program_regs(input int dz, input int gain, input int lo_deg,
                              input int hi_deg, input int lost);
    wait_idle();
    write_reg(CFG_DEADBAND, dz);
    write_reg(CFG_LOOP_GAIN, gain);
    write_reg(CFG_ANGLE_FLOOR, lo_deg);
    write_reg(CFG_ANGLE_CEILING, hi_deg);
    write_reg(CFG_LOST_THRESHOLD, lost);
    cfg_valid <= 1'b0;
  endtask

  // Modes: 0 hit anywhere in the 9-bit range, 1 hit straddling the dead zone,
  // 2 hit inside the image, 3 noise (found random), 4 miss
  function automatic detect_req_t make_frame(int mode);
    detect_req_t req;
    int span;
    int sum_x;
    int sum_y;
    req.found  = (mode == 3) ? 1'($urandom_range(1)) : (mode != 4);
    req.left   = COORD_W'($urandom_range(511));
    req.top    = COORD_W'($urandom_range(511));
    req.right  = COORD_W'($urandom_range(511));
    req.bottom = COORD_W'($urandom_range(511));
    if (mode == 1) begin
      // pick coordinate sums that put each error within a few pixels of the dead zone
      span  = int'(deadband_q) + 3;
      sum_x = 2 * (IMG_WIDTH - 1 - HALF_W) + int'($urandom_range(4 * span)) - 2 * span;
      sum_y = 2 * HALF_H + int'($urandom_range(4 * span)) - 2 * span;
      if (sum_x < 0) sum_x = 0;
      if (sum_y < 0) sum_y = 0;
      req.left   = COORD_W'(sum_x / 2 - int'($urandom_range(sum_x / 2)));
      req.right  = COORD_W'(sum_x - int'(req.left));
      req.top    = COORD_W'(sum_y / 2 - int'($urandom_range(sum_y / 2)));
      req.bottom = COORD_W'(sum_y - int'(req.top));
    end else if (mode == 2) begin
      req.left   = COORD_W'($urandom_range(IMG_WIDTH - 1));
      req.right  = COORD_W'($urandom_range(IMG_WIDTH - 1));
      req.top    = COORD_W'($urandom_range(IMG_HEIGHT - 1));
      req.bottom = COORD_W'($urandom_range(IMG_HEIGHT - 1));
    end
    return req;
  endfunction

  task automatic program_random();
    int dz;
    int gain;
    int lo_deg;
    int hi_deg;
    int lost;
    int pick;
    int tmp;
    pick = $urandom_range(3);
    dz   = (pick == 0) ? 0 : (pick == 1) ? 127 : int'($urandom_range(127));
    pick = $urandom_range(4);
    gain = (pick == 0) ? 0 : (pick == 1) ? 65535 :
           (pick == 2) ? int'($urandom_range(65535)) : int'($urandom_range(2048));
    lo_deg = ($urandom_range(5) == 0) ? 0 : int'($urandom_range(180));
    hi_deg = ($urandom_range(5) == 0) ? 180 : int'($urandom_range(180));
    // mostly a sane window, sometimes an inverted one
    if (lo_deg > hi_deg && $urandom_range(4) != 0) begin
      tmp    = lo_deg;
      lo_deg = hi_deg;
      hi_deg = tmp;
    end
    pick = $urandom_range(5);
    lost = (pick == 0) ? 0 : (pick == 1) ? 254 :
           (pick == 2) ? int'($urandom_range(254)) : int'($urandom_range(12));
    program_regs(dz, gain, lo_deg, hi_deg, lost);
  endtask

  //--------------------------------------------------------------------------
  // Tests
  //--------------------------------------------------------------------------

  // Reset register values: center, extremes, dead-zone edges both sides
  task automatic test_reset_defaults();
    send_frame(make_frame(4));                                // quiet miss
    send_frame(detect_req_t'{1'b1, 9'd79, 9'd60, 9'd79, 9'd60});   // dead center
    send_frame(detect_req_t'{1'b1, 9'd0, 9'd511, 9'd0, 9'd511});   // far left/bottom
    send_frame(detect_req_t'{1'b1, 9'd511, 9'd0, 9'd511, 9'd0});   // far right/top
    send_frame(detect_req_t'{1'b1, 9'd69, 9'd70, 9'd69, 9'd70});   // errors +10: hold
    send_frame(detect_req_t'{1'b1, 9'd68, 9'd71, 9'd69, 9'd71});   // +11, odd sum
    send_frame(detect_req_t'{1'b1, 9'd89, 9'd50, 9'd89, 9'd50});   // errors -10: hold
    send_frame(detect_req_t'{1'b1, 9'd90, 9'd49, 9'd90, 9'd49});   // -11, truncation
    send_frame(detect_req_t'{1'b0, 9'd511, 9'd511, 9'd511, 9'd511});
  endtask

  // Clamping: full gain into both limits, floor=ceiling=180, floor above ceiling,
  // widest dead zone, zero gain
  task automatic test_clamp_limits();
    program_regs(0, 65535, 0, 180, 254);
    send_frame(detect_req_t'{1'b1, 9'd0, 9'd511, 9'd0, 9'd511});
    send_frame(detect_req_t'{1'b1, 9'd511, 9'd0, 9'd511, 9'd0});
    program_regs(0, 65535, 180, 180, 254);
    send_frame(detect_req_t'{1'b1, 9'd70, 9'd65, 9'd70, 9'd65});
    program_regs(0, 65535, 120, 60, 254);
    send_frame(detect_req_t'{1'b1, 9'd0, 9'd511, 9'd0, 9'd511});
    send_frame(detect_req_t'{1'b1, 9'd511, 9'd0, 9'd511, 9'd0});
    program_regs(127, 65535, 0, 180, 254);
    send_frame(detect_req_t'{1'b1, 9'd206, 9'd187, 9'd206, 9'd187});   // |err| 127: hold
    send_frame(detect_req_t'{1'b1, 9'd207, 9'd188, 9'd207, 9'd188});   // |err| 128: move
    program_regs(0, 0, 0, 180, 254);
    send_frame(detect_req_t'{1'b1, 9'd0, 9'd511, 9'd0, 9'd511});
  endtask

  // Lost-face drift: step toward center, snap inside the window, threshold edge
  task automatic test_recenter();
    program_regs(0, 65535, 88, 92, 0);
    send_frame(detect_req_t'{1'b1, 9'd0, 9'd511, 9'd0, 9'd511});   // pan 92, tilt 88
    program_regs(0, 512, 0, 180, 0);
    send_frame(make_frame(4));   // one degree step each
    send_frame(make_frame(4));   // snap, nothing moved
    send_frame(detect_req_t'{1'b1, 9'd78, 9'd61, 9'd78, 9'd61});   // fractional offset
    send_frame(make_frame(4));
    program_regs(0, 512, 0, 180, 2);
    send_frame(detect_req_t'{1'b1, 9'd0, 9'd0, 9'd0, 9'd0});
    repeat (4) send_frame(make_frame(4));
  endtask

  // Miss counter must stick at its maximum instead of wrapping
  task automatic test_miss_saturation();
    program_regs(10, 512, 10, 170, 254);
    send_frame(detect_req_t'{1'b1, 9'd0, 9'd511, 9'd0, 9'd511});
    repeat (258) send_frame(make_frame(4));
    send_frame(make_frame(0));
    repeat (2) send_frame(make_frame(4));
  endtask

  // Tracking episodes: a burst of hit and noise frames, then a run of misses sized around the
  // lost threshold so that many runs reach and walk through recentering
  task automatic test_random_tracking(input int n_frames);
    int sent;
    int burst;
    int k;
    sent = 0;
    while (sent < n_frames) begin
      if ($urandom_range(4) == 0) program_random();
      burst = $urandom_range(1, 6);
      if (burst > n_frames - sent) burst = n_frames - sent;
      for (k = 0; k < burst; k++) send_frame(make_frame($urandom_range(3)));
      sent += burst;
      burst = $urandom_range(int'(lost_limit_q) + 40);
      if (burst > 100) burst = $urandom_range(100);
      if (burst > n_frames - sent) burst = n_frames - sent;
      for (k = 0; k < burst; k++) send_frame(make_frame(4));
      sent += burst;
    end
  endtask

  initial begin
    int drain;
    rst          = 1'b1;
    in_valid     = 1'b0;
    face_found   = 1'b0;
    box_left     = '0;
    box_top      = '0;
    box_right    = '0;
    box_bottom   = '0;
    out_stall    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_DEADBAND;
    cfg_data     = '0;
    deadband_q   = DEADBAND_RST;
    loop_gain_q  = LOOP_GAIN_RST;
    floor_deg_q  = ANGLE_FLOOR_RST;
    ceil_deg_q   = ANGLE_CEILING_RST;
    lost_limit_q = LOST_THRESHOLD_RST;
    pan_q        = CENTRE_Q;
    tilt_q       = CENTRE_Q;
    missed_q     = '0;
    in_gap_pct    = 17;
    out_stall_pct = 48;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_clamp_limits();
    test_recenter();
    test_miss_saturation();
    test_random_tracking(75);
    in_gap_pct    = 48;
    out_stall_pct = 17;
    test_random_tracking(75);
    in_gap_pct    = 0;
    out_stall_pct = 0;
    test_random_tracking(75);

    // drain, then give the pipeline time to show any stray result
    in_valid <= 1'b0;
    for (drain = 0; drain < DRAIN_LIMIT && expected_cmds.size() != 0; drain++)
      @(negedge clk);
    repeat (PIPE_DEPTH * 2) @(negedge clk);
    if (expected_cmds.size() != 0)
      log_mismatch("requests without a result", expected_cmds[0], '0);
    if (bad_results == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
